// ===== design/lphi_pkg.sv =====
// lphi_pkg: shared types and constants for the linear probing hash insert block
// holds the request/response transaction structs, queue item type and status codes
// no dependencies
package lphi_pkg;

  localparam int unsigned HashBitsDefault = 8;
  localparam logic [63:0] GoldenMult = 64'h9E37_79B9_7F4A_7C15;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_KEYZERO = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [63:0] key;
    logic [31:0] entry_size;
  } req_t;

  typedef struct packed {
    logic [7:0] slot;
    logic [1:0] status;
    logic [8:0] entry_count;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_CLEAR,
    OP_KEYZERO
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] key;
    logic [31:0] entry_size;
  } q_item_t;

endpackage

// ===== design/lphi_queue.sv =====
// lphi_queue: two-entry fifo between the front and back parts
// depends on nothing but its data width parameter
module lphi_queue #(
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [DataW-1:0] pop_data_o,
  output logic             empty_o
);

  logic [DataW-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== design/lphi_front.sv =====
// lphi_front: accepts request transactions, classifies them and computes the home slot
// fibonacci hash through a shared 32x32 multiplier, stepped over the low and two middle partial products; uses lphi_pkg
module lphi_front
  import lphi_pkg::*;
#(
  parameter int unsigned HashBits = HashBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  req_t                                 req_i,
  output logic                                 busy_o,
  input  logic                                 q_full_i,
  output logic                                 push_o,
  output logic [$bits(q_item_t)+HashBits-1:0]  push_data_o
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } f_state_e;

  typedef enum logic [1:0] {
    MS_LO,
    MS_MID_A,
    MS_MID_B
  } mul_step_e;

  f_state_e      state_q;
  mul_step_e     step_q;
  req_t          req_q;
  op_e           op_q;
  logic [63:0]   lo_q;
  logic [31:0]   mid_q;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic [31:0]   hash_hi;
  logic [HashBits-1:0] home;
  q_item_t       item;

  always_comb begin
    case (step_q)
      MS_LO: begin
        mul_a = req_q.key[31:0];
        mul_b = GoldenMult[31:0];
      end
      MS_MID_A: begin
        mul_a = req_q.key[31:0];
        mul_b = GoldenMult[63:32];
      end
      MS_MID_B: begin
        mul_a = req_q.key[63:32];
        mul_b = GoldenMult[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = 64'(mul_a) * 64'(mul_b);
  assign hash_hi = lo_q[63:32] + mid_q;
  assign home    = hash_hi[31 -: HashBits];

  assign item.op         = op_q;
  assign item.key        = req_q.key;
  assign item.entry_size = req_q.entry_size;

  assign busy_o      = (state_q != F_IDLE);
  assign push_o      = (state_q == F_PUSH) && !q_full_i;
  assign push_data_o = {item, home};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= MS_LO;
      req_q   <= '0;
      op_q    <= OP_INSERT;
      lo_q    <= '0;
      mid_q   <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (accept_i) begin
            req_q  <= req_i;
            step_q <= MS_LO;
            if (req_i.req_type == REQ_CLEAR) begin
              op_q    <= OP_CLEAR;
              state_q <= F_PUSH;
            end else if (req_i.key == 64'd0) begin
              op_q    <= OP_KEYZERO;
              state_q <= F_PUSH;
            end else begin
              op_q    <= OP_INSERT;
              state_q <= F_MUL;
            end
          end
        end
        F_MUL: begin
          case (step_q)
            MS_LO: begin
              lo_q   <= prod;
              step_q <= MS_MID_A;
            end
            MS_MID_A: begin
              mid_q  <= prod[31:0];
              step_q <= MS_MID_B;
            end
            MS_MID_B: begin
              mid_q   <= mid_q + prod[31:0];
              step_q  <= MS_LO;
              state_q <= F_PUSH;
            end
            default: begin
              step_q <= MS_LO;
            end
          endcase
        end
        F_PUSH: begin
          if (!q_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/lphi_back.sv =====
// lphi_back: carries out queued requests against the slot table and issues results
// owns the valid, key and size memories and the occupied count; uses lphi_pkg
module lphi_back
  import lphi_pkg::*;
#(
  parameter int unsigned HashBits = HashBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_empty_i,
  input  logic [$bits(q_item_t)+HashBits-1:0]  pop_data_i,
  output logic                                 pop_o,
  output logic                                 init_o,
  output logic                                 done_o,
  output rsp_t                                 rsp_o
);

  localparam int unsigned TableSize = 1 << HashBits;
  localparam int unsigned CntW      = HashBits + 1;

  typedef enum logic [2:0] {
    B_INIT_CLR,
    B_IDLE,
    B_CLR,
    B_RD,
    B_CHK
  } b_state_e;

  b_state_e            state_q;
  logic [HashBits-1:0] clr_addr_q;
  logic [HashBits-1:0] pos_q;
  logic [CntW-1:0]     count_q;
  logic [63:0]         key_q;
  logic [31:0]         size_q;
  logic                done_q;
  rsp_t                rsp_q;
  logic                vrd_q;

  logic                valid_mem [TableSize];
  logic [63:0]         key_mem   [TableSize];
  logic [31:0]         size_mem  [TableSize];

  q_item_t             item;
  logic [HashBits-1:0] home;
  logic                v_we;
  logic [HashBits-1:0] v_addr;
  logic                v_wdata;
  logic                store;
  logic                clr_last;

  assign {item, home} = pop_data_i;

  assign pop_o    = (state_q == B_IDLE) && !q_empty_i;
  assign init_o   = (state_q == B_INIT_CLR);
  assign done_o   = done_q;
  assign rsp_o    = rsp_q;
  assign store    = (state_q == B_CHK) && !vrd_q;
  assign clr_last = (clr_addr_q == {HashBits{1'b1}});

  always_comb begin
    v_we    = 1'b0;
    v_addr  = pos_q;
    v_wdata = 1'b1;
    if (state_q == B_INIT_CLR || state_q == B_CLR) begin
      v_we    = 1'b1;
      v_addr  = clr_addr_q;
      v_wdata = 1'b0;
    end else if (store) begin
      v_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      valid_mem[v_addr] <= v_wdata;
    end
    vrd_q <= valid_mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      key_mem[pos_q]  <= key_q;
      size_mem[pos_q] <= size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_INIT_CLR;
      clr_addr_q <= '0;
      pos_q      <= '0;
      count_q    <= '0;
      key_q      <= '0;
      size_q     <= '0;
      done_q     <= 1'b0;
      rsp_q      <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        B_INIT_CLR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_last) begin
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop_o) begin
            case (item.op)
              OP_CLEAR: begin
                clr_addr_q <= '0;
                count_q    <= '0;
                state_q    <= B_CLR;
              end
              OP_KEYZERO: begin
                done_q            <= 1'b1;
                rsp_q.slot        <= '0;
                rsp_q.status      <= ST_KEYZERO;
                rsp_q.entry_count <= 9'(count_q);
              end
              OP_INSERT: begin
                if (count_q == CntW'(TableSize)) begin
                  done_q            <= 1'b1;
                  rsp_q.slot        <= '0;
                  rsp_q.status      <= ST_FULL;
                  rsp_q.entry_count <= 9'(count_q);
                end else begin
                  pos_q   <= home;
                  key_q   <= item.key;
                  size_q  <= item.entry_size;
                  state_q <= B_RD;
                end
              end
              default: begin
                state_q <= B_IDLE;
              end
            endcase
          end
        end
        B_CLR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_last) begin
            done_q            <= 1'b1;
            rsp_q.slot        <= '0;
            rsp_q.status      <= ST_OK;
            rsp_q.entry_count <= '0;
            state_q           <= B_IDLE;
          end
        end
        B_RD: begin
          state_q <= B_CHK;
        end
        B_CHK: begin
          if (!vrd_q) begin
            count_q           <= count_q + 1'b1;
            done_q            <= 1'b1;
            rsp_q.slot        <= 8'(pos_q);
            rsp_q.status      <= ST_OK;
            rsp_q.entry_count <= 9'(count_q + 1'b1);
            state_q           <= B_IDLE;
          end else begin
            pos_q   <= pos_q + 1'b1;
            state_q <= B_RD;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/linear_probe_hash_insert.sv =====
// linear_probe_hash_insert: top level of the open addressing hash table insert block
// ties front (accept, classify, hash), the queue and the back (probe, store, clear)
// uses lphi_pkg, lphi_front, lphi_queue, lphi_back
//
// a request transaction is taken at a rising edge where start is high and busy is low;
// req_i.req_type selects insert or clear of the whole table
// every request gives exactly one result on rsp_o, marked by done_o for one cycle;
// the receiver cannot stall, so results are never held back
// the front holds busy after an insert while three steps of the shared 32x32
// multiplier form the fibonacci hash, then while it pushes into a two-entry queue
// (longer while the queue is full); clear and key zero go straight to the push
// the back probes the valid memory slot by slot (registered read, then check and
// write), and a free slot found by the check raises done_o; key zero and full
// raise done_o straight from the idle pop, with no probing
// a clear walks the valid memory one slot a cycle, raising done_o after the last slot
// after reset the same clearing pass runs over every slot with busy high
// the front may accept new requests while the back is still probing
module linear_probe_hash_insert
  import lphi_pkg::*;
#(
  parameter int unsigned HASH_BITS = HashBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned QDataW = $bits(q_item_t) + HASH_BITS;

  logic              front_busy;
  logic              init;
  logic              accept;
  logic              push, q_full, pop, q_empty;
  logic [QDataW-1:0] push_data, pop_data;

  assign busy   = front_busy || init;
  assign accept = start && !busy;

  lphi_front #(
    .HashBits(HASH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (req_i),
    .busy_o     (front_busy),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  lphi_queue #(
    .DataW(QDataW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (q_empty)
  );

  lphi_back #(
    .HashBits(HASH_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .pop_data_i(pop_data),
    .pop_o     (pop),
    .init_o    (init),
    .done_o    (done_o),
    .rsp_o     (rsp_o)
  );

endmodule
